// ===== hw/rtl/voice_release_tracker_defines.svh =====
// Assertion macros shared by the voice release tracker RTL.
`ifndef VOICE_RELEASE_TRACKER_DEFINES_SVH
`define VOICE_RELEASE_TRACKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define VRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("voice release tracker: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define VRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("voice release tracker: next-cycle check failed");

`endif

// ===== hw/rtl/vrt_pkg.sv =====
// Types, codes and the release duration table of the voice release tracker.
package vrt_pkg;

  localparam int VOICE_COUNT_DEF = 24;
  localparam int TIME_WIDTH_DEF  = 32;
  localparam int DUR_W           = 15;

  typedef enum logic [1:0] {
    ACT_NOTE_ON  = 2'd0,
    ACT_NOTE_OFF = 2'd1,
    ACT_TONE     = 2'd2,
    ACT_QUERY    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    PH_INACTIVE = 2'd0,
    PH_KEYON    = 2'd1,
    PH_RELEASE  = 2'd2
  } phase_t;

  typedef struct packed {
    action_t     action;
    logic [4:0]  voice;
    logic [3:0]  release_rate;
    logic        layout_matches;
    logic        voice_enabled;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [4:0]  served_voice;
    logic        note_active;
    phase_t      voice_phase;
    logic [31:0] deadline_ms;
    logic        accepted;
  } rsp_t;

  // Release length in ms for a rate; rate 0 has no finite release.
  function automatic logic [DUR_W-1:0] release_duration(input logic [3:0] rate);
    logic [DUR_W-1:0] dur;
    unique case (rate)
      4'd1:    dur = 15'd25600;
      4'd2:    dur = 15'd12800;
      4'd3:    dur = 15'd6400;
      4'd4:    dur = 15'd3200;
      4'd5:    dur = 15'd1600;
      4'd6:    dur = 15'd800;
      4'd7:    dur = 15'd400;
      4'd8:    dur = 15'd200;
      4'd9:    dur = 15'd100;
      4'd10:   dur = 15'd50;
      4'd11:   dur = 15'd25;
      4'd12:   dur = 15'd13;
      4'd13:   dur = 15'd7;
      4'd14:   dur = 15'd4;
      4'd15:   dur = 15'd2;
      default: dur = '0;
    endcase
    return dur;
  endfunction

endpackage

// ===== hw/rtl/vrt_tables.sv =====
// Per-voice phase, deadline and release rate registers with one read and one write port.
module vrt_tables #(
  parameter int VOICE_COUNT = vrt_pkg::VOICE_COUNT_DEF,
  parameter int TIME_WIDTH  = vrt_pkg::TIME_WIDTH_DEF,
  localparam int VIDX_W     = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [VIDX_W-1:0]     idx,
  output vrt_pkg::phase_t       rd_phase,
  output logic [TIME_WIDTH-1:0] rd_deadline,
  output logic [3:0]            rd_rate,
  input  logic                  wr_en,
  input  vrt_pkg::phase_t       wr_phase,
  input  logic [TIME_WIDTH-1:0] wr_deadline,
  input  logic [3:0]            wr_rate
);
  import vrt_pkg::*;

  phase_t                phase_tab    [VOICE_COUNT];
  logic [TIME_WIDTH-1:0] deadline_tab [VOICE_COUNT];
  logic [3:0]            rate_tab     [VOICE_COUNT];

  // Read the addressed voice
  assign rd_phase    = phase_tab[idx];
  assign rd_deadline = deadline_tab[idx];
  assign rd_rate     = rate_tab[idx];

  // Clear all voices on reset, write back the updated entry
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        phase_tab[i]    <= PH_INACTIVE;
        deadline_tab[i] <= '0;
        rate_tab[i]     <= '0;
      end
    end else if (wr_en) begin
      phase_tab[idx]    <= wr_phase;
      deadline_tab[idx] <= wr_deadline;
      rate_tab[idx]     <= wr_rate;
    end
  end

endmodule

// ===== hw/rtl/vrt_update.sv =====
// Next voice entry and result for one request, from the stored entry.
module vrt_update #(
  parameter int VOICE_COUNT = vrt_pkg::VOICE_COUNT_DEF,
  parameter int TIME_WIDTH  = vrt_pkg::TIME_WIDTH_DEF
) (
  input  vrt_pkg::req_t         req,
  input  vrt_pkg::phase_t       rd_phase,
  input  logic [TIME_WIDTH-1:0] rd_deadline,
  input  logic [3:0]            rd_rate,
  output logic                  in_range,
  output vrt_pkg::phase_t       new_phase,
  output logic [TIME_WIDTH-1:0] new_deadline,
  output logic [3:0]            new_rate,
  output vrt_pkg::rsp_t         rsp
);
  import vrt_pkg::*;

  logic [TIME_WIDTH-1:0] now_t;
  logic [3:0]            calc_rate;
  logic [TIME_WIDTH:0]   sum;
  logic [TIME_WIDTH-1:0] calc_deadline;
  logic                  active;
  logic                  acc;

  assign in_range = 32'(req.voice) < 32'(VOICE_COUNT);
  assign now_t    = TIME_WIDTH'(req.now_ms);

  // Note off uses the stored rate, tone change the new one
  assign calc_rate = (req.action == ACT_NOTE_OFF) ? rd_rate : req.release_rate;
  assign sum = {1'b0, now_t} + (TIME_WIDTH + 1)'(release_duration(calc_rate));

  // Saturate on overflow; rate 0 keeps the endless deadline of zero
  always_comb begin
    if (calc_rate == 4'd0) begin
      calc_deadline = '0;
    end else if (sum[TIME_WIDTH]) begin
      calc_deadline = '1;
    end else begin
      calc_deadline = sum[TIME_WIDTH-1:0];
    end
  end

  // Apply the action to the stored entry
  always_comb begin
    new_phase    = rd_phase;
    new_deadline = rd_deadline;
    new_rate     = rd_rate;
    active       = 1'b0;
    acc          = 1'b1;
    unique case (req.action)
      ACT_NOTE_ON: begin
        new_phase    = PH_KEYON;
        new_deadline = '0;
      end
      ACT_NOTE_OFF: begin
        if (req.voice_enabled) begin
          new_phase    = PH_RELEASE;
          new_deadline = calc_deadline;
        end
      end
      ACT_TONE: begin
        if (!req.layout_matches) begin
          acc = 1'b0;
        end else begin
          if (rd_phase == PH_RELEASE && rd_rate != req.release_rate) begin
            new_deadline = calc_deadline;
          end
          new_rate = req.release_rate;
        end
      end
      ACT_QUERY: begin
        priority if (!req.voice_enabled) begin
          new_phase = PH_INACTIVE;
        end else if (rd_phase == PH_KEYON) begin
          active = 1'b1;
        end else if (rd_phase != PH_RELEASE) begin
          active = 1'b0;
        end else if (rd_deadline == '0) begin
          active = 1'b1;
        end else if (now_t >= rd_deadline) begin
          new_phase = PH_INACTIVE;
        end else begin
          active = 1'b1;
        end
      end
      default: begin
        acc = 1'b1;
      end
    endcase
  end

  // Build the result; an out-of-range voice echoes only its index
  always_comb begin
    rsp.served_voice = req.voice;
    if (in_range) begin
      rsp.note_active = active;
      rsp.voice_phase = new_phase;
      rsp.deadline_ms = 32'(new_deadline);
      rsp.accepted    = acc;
    end else begin
      rsp.note_active = 1'b0;
      rsp.voice_phase = PH_INACTIVE;
      rsp.deadline_ms = '0;
      rsp.accepted    = 1'b0;
    end
  end

endmodule

// ===== hw/rtl/voice_release_tracker.sv =====
// A request sits in the input register while its result is computed from the per-voice
// registers; the result is loaded into the result register when that register is free or
// being drained, and is held there until rsp_ready takes it.
// Throughput: one request per cycle while the result register is drained, set by the
// read-modify-write of the per-voice registers between the input and result registers.
// Reset (synchronous): all voices inactive, deadlines and rates zero, both stages empty.
`include "voice_release_tracker_defines.svh"

module voice_release_tracker #(
  parameter int VOICE_COUNT = vrt_pkg::VOICE_COUNT_DEF,
  parameter int TIME_WIDTH  = vrt_pkg::TIME_WIDTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  vrt_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output vrt_pkg::rsp_t rsp
);
  import vrt_pkg::*;

  localparam int VIDX_W = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  req_t                  req_q;
  logic                  s1_valid;
  logic                  s1_adv;
  logic                  in_range;
  logic                  wr_en;
  phase_t                rd_phase;
  phase_t                new_phase;
  logic [TIME_WIDTH-1:0] rd_deadline;
  logic [TIME_WIDTH-1:0] new_deadline;
  logic [3:0]            rd_rate;
  logic [3:0]            new_rate;
  rsp_t                  rsp_next;
  logic                  rsp_out_of_range;
  logic                  rsp_no_deadline;
  logic                  rsp_refused;

  // Advance when the result register is free or being drained
  assign s1_adv    = !rsp_valid || rsp_ready;
  assign req_ready = !s1_valid || s1_adv;
  assign wr_en     = s1_valid && s1_adv && in_range;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_ready) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req;
    end
  end

  vrt_tables #(
    .VOICE_COUNT(VOICE_COUNT),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_tables (
    .clk        (clk),
    .rst        (rst),
    .idx        (VIDX_W'(req_q.voice)),
    .rd_phase   (rd_phase),
    .rd_deadline(rd_deadline),
    .rd_rate    (rd_rate),
    .wr_en      (wr_en),
    .wr_phase   (new_phase),
    .wr_deadline(new_deadline),
    .wr_rate    (new_rate)
  );

  vrt_update #(
    .VOICE_COUNT(VOICE_COUNT),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_update (
    .req         (req_q),
    .rd_phase    (rd_phase),
    .rd_deadline (rd_deadline),
    .rd_rate     (rd_rate),
    .in_range    (in_range),
    .new_phase   (new_phase),
    .new_deadline(new_deadline),
    .new_rate    (new_rate),
    .rsp         (rsp_next)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  assign rsp_out_of_range = rsp_valid && 32'(rsp.served_voice) >= 32'(VOICE_COUNT);
  assign rsp_no_deadline  = rsp.deadline_ms == '0;
  assign rsp_refused      = !rsp.accepted && rsp.voice_phase == PH_INACTIVE && rsp_no_deadline;

  `VRT_ASSERT_NEXT(a_accept_fills_stage, req_valid && req_ready, s1_valid)
  `VRT_ASSERT_NOW(a_range_refused, rsp_out_of_range, rsp_refused)
  `VRT_ASSERT_NOW(a_active_not_idle, rsp_valid && rsp.note_active, rsp.voice_phase != PH_INACTIVE)
  `VRT_ASSERT_NOW(a_keyon_no_deadline, rsp_valid && rsp.voice_phase == PH_KEYON, rsp_no_deadline)

endmodule
